// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by btpc_fifo; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/btpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Types, constants and helpers of the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;
  localparam int FRONT_STAGES  = 10;
  localparam int DIV_BITS      = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_T1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T23    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P23    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P45    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P67    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P89    = 3'd6;

  localparam logic [31:0] FINE_OFFSET  = 32'd64000;
  localparam logic [31:0] PRESS_BASE   = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE  = 32'd3125;
  localparam logic [31:0] P1_OFFSET    = 32'd32768;
  localparam logic [31:0] CENTI_ROUND  = 32'd128;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               divide_guard;
  } out_word_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] pnum;
    logic [31:0] div;
  } mid_word_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned sh);
    asr = 32'($signed(x) >>> sh);
  endfunction

endpackage

// ===== sv/btpc_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// btpc_fifo
// Small flop-based word queue with show-ahead read.
// ----------------------------------------------------------------------------
module btpc_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)
  `ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, empty, wr_ptr_r == rd_ptr_r)
  `ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !empty)

endmodule

// ===== sv/btpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_front
// Raw assembly, temperature and pressure divisor/numerator pipeline.
// ----------------------------------------------------------------------------
module btpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  btpc_pkg::coef_t     coef,
  input  logic                in_push,
  input  btpc_pkg::in_word_t  in_data,
  output logic                in_full,
  input  logic                mid_full,
  output logic                mid_push,
  output btpc_pkg::mid_word_t mid_data
);

  localparam int NS = btpc_pkg::FRONT_STAGES;

  typedef struct packed {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [31:0] a_prod;
    logic [31:0] b_sq;
    logic [31:0] v1t;
    logic [31:0] t3_prod;
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] pv1;
    logic [31:0] qq;
    logic [31:0] p5_prod;
    logic [31:0] p2_prod;
    logic [31:0] p6_prod;
    logic [31:0] p3_prod;
    logic [31:0] v2;
    logic [31:0] v1p;
    logic [31:0] p1_prod;
    logic [31:0] pnum;
    logic [31:0] div;
  } fstage_t;

  fstage_t       st_r   [NS];
  fstage_t       st_nxt [NS];
  logic [NS-1:0] vld_r, vld_nxt;
  logic          en;
  logic          accept;
  logic [31:0]   a_w, b_w, q_w;

  assign en       = !(vld_r[NS-1] && mid_full);
  assign in_full  = !en;
  assign accept   = in_push && en;
  assign mid_push = vld_r[NS-1] && en;
  assign mid_data = '{fine: st_r[NS-1].fine, centi: st_r[NS-1].centi,
                      pnum: st_r[NS-1].pnum, div: st_r[NS-1].div};

  assign vld_nxt = {vld_r[NS-2:0], accept};

  always_comb begin
    a_w = (32'(st_r[0].adc_t) >> 3) - (32'(coef.t1) << 1);
    b_w = (32'(st_r[0].adc_t) >> 4) - 32'(coef.t1);
    q_w = btpc_pkg::asr(st_r[4].pv1, 2);
    st_nxt[0] = st_r[0];
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = st_r[k-1];
    end
    st_nxt[0].adc_t = {in_data.temp_msb, in_data.temp_lsb, in_data.temp_xlsb[7:4]};
    st_nxt[0].adc_p = {in_data.press_msb, in_data.press_lsb, in_data.press_xlsb[7:4]};
    st_nxt[1].a_prod  = 32'(a_w * btpc_pkg::sx16(coef.t2));
    st_nxt[1].b_sq    = 32'(b_w * b_w);
    st_nxt[2].v1t     = btpc_pkg::asr(st_r[1].a_prod, 11);
    st_nxt[2].t3_prod = 32'(btpc_pkg::asr(st_r[1].b_sq, 12) * btpc_pkg::sx16(coef.t3));
    st_nxt[3].fine    = st_r[2].v1t + btpc_pkg::asr(st_r[2].t3_prod, 14);
    st_nxt[4].centi   = btpc_pkg::asr((st_r[3].fine << 2) + st_r[3].fine
                                      + btpc_pkg::CENTI_ROUND, 8);
    st_nxt[4].pv1     = btpc_pkg::asr(st_r[3].fine, 1) - btpc_pkg::FINE_OFFSET;
    st_nxt[5].qq      = 32'(q_w * q_w);
    st_nxt[5].p5_prod = 32'(st_r[4].pv1 * btpc_pkg::sx16(coef.p5));
    st_nxt[5].p2_prod = 32'(st_r[4].pv1 * btpc_pkg::sx16(coef.p2));
    st_nxt[6].p6_prod = 32'(btpc_pkg::asr(st_r[5].qq, 11) * btpc_pkg::sx16(coef.p6));
    st_nxt[6].p3_prod = 32'(btpc_pkg::asr(st_r[5].qq, 13) * btpc_pkg::sx16(coef.p3));
    st_nxt[7].v2      = btpc_pkg::asr(st_r[6].p6_prod + (st_r[6].p5_prod << 1), 2)
                        + (btpc_pkg::sx16(coef.p4) << 16);
    st_nxt[7].v1p     = btpc_pkg::asr(btpc_pkg::asr(st_r[6].p3_prod, 3)
                                      + btpc_pkg::asr(st_r[6].p2_prod, 1), 18);
    st_nxt[8].p1_prod = 32'((btpc_pkg::P1_OFFSET + st_r[7].v1p) * 32'(coef.p1));
    st_nxt[8].pnum    = 32'(((btpc_pkg::PRESS_BASE - 32'(st_r[7].adc_p))
                             - btpc_pkg::asr(st_r[7].v2, 12)) * btpc_pkg::PRESS_SCALE);
    st_nxt[9].div     = btpc_pkg::asr(st_r[8].p1_prod, 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/btpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_back
// Pipelined restoring divider and pressure correction.
// ----------------------------------------------------------------------------
module btpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  btpc_pkg::coef_t     coef,
  input  logic                mid_empty,
  input  btpc_pkg::mid_word_t mid_data,
  output logic                mid_pop,
  input  logic                out_full,
  output logic                out_push,
  output btpc_pkg::out_word_t out_data
);

  localparam int ND = btpc_pkg::DIV_BITS;
  localparam int NS = ND + 4;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] div;
    logic [31:0] rem;
    logic [31:0] num;
    logic        hi;
    logic        guard;
    logic [31:0] p;
    logic [31:0] sq;
    logic [31:0] p8_prod;
    logic [31:0] p9_prod;
    logic [31:0] res;
  } bstage_t;

  bstage_t       st_r   [NS];
  bstage_t       st_nxt [NS];
  logic [NS-1:0] vld_r, vld_nxt;
  logic          en;
  logic [32:0]   trial [ND];
  logic          ge [ND];
  logic [31:0]   pq, p3w, sum_w;

  assign en       = !(vld_r[NS-1] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = vld_r[NS-1] && en;
  assign out_data = '{fine_temperature:  $signed(st_r[NS-1].fine),
                      temperature_centi: $signed(st_r[NS-1].centi),
                      pressure_pa:       st_r[NS-1].res,
                      divide_guard:      st_r[NS-1].guard};

  assign vld_nxt = {vld_r[NS-2:0], !mid_empty};

  always_comb begin
    st_nxt[0] = st_r[0];
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = st_r[k-1];
    end
    st_nxt[0].fine  = mid_data.fine;
    st_nxt[0].centi = mid_data.centi;
    st_nxt[0].div   = mid_data.div;
    st_nxt[0].hi    = mid_data.pnum[31];
    st_nxt[0].guard = (mid_data.div == '0);
    st_nxt[0].num   = mid_data.pnum[31] ? mid_data.pnum : (mid_data.pnum << 1);
    st_nxt[0].rem   = '0;
    for (int k = 0; k < ND; k++) begin
      trial[k] = {st_r[k].rem, st_r[k].num[31]};
      ge[k]    = (trial[k] >= {1'b0, st_r[k].div});
      st_nxt[k+1].rem = ge[k] ? 32'(trial[k] - {1'b0, st_r[k].div}) : trial[k][31:0];
      st_nxt[k+1].num = {st_r[k].num[30:0], ge[k]};
    end
    pq  = st_r[ND].hi ? (st_r[ND].num << 1) : st_r[ND].num;
    p3w = pq >> 3;
    st_nxt[ND+1].p       = pq;
    st_nxt[ND+1].sq      = 32'(p3w * p3w);
    st_nxt[ND+1].p8_prod = 32'((pq >> 2) * btpc_pkg::sx16(coef.p8));
    st_nxt[ND+2].p9_prod = 32'(btpc_pkg::sx16(coef.p9) * (st_r[ND+1].sq >> 13));
    sum_w = btpc_pkg::asr(st_r[ND+2].p9_prod, 12) + btpc_pkg::asr(st_r[ND+2].p8_prod, 13)
            + btpc_pkg::sx16(coef.p7);
    st_nxt[ND+3].res = st_r[ND+2].guard ? '0
                       : st_r[ND+2].p + btpc_pkg::asr(sum_w, 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Barometric temperature and pressure compensation, 32-bit integer form.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data with the six raw sensor bytes and raise
//   in_push; the word is taken at a clock edge with in_full low.
//   Result queue: while out_empty is low, out_data holds the oldest result
//   (fine temperature, centi-degrees, pascals, divide guard); pop takes it.
//   Calibration: write cfg_wdata to register cfg_index with cfg_we, only
//   while no words are in flight.
// Timing:
//   One word per cycle sustained while out_pop keeps up. From the push edge
//   to out_empty falling a word passes 10 front stages, the middle queue,
//   36 back stages (an input stage, one per quotient bit of the 32-bit
//   divider and 3 correction stages) and the result queue.
// Reset:
//   rst_n clears all calibration words to zero and empties both queues.
// Stall:
//   When pop stays low the result queue fills, the back pipeline holds,
//   the middle queue fills, the front holds and in_full rises.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation #(
  parameter int MID_DEPTH = btpc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = btpc_pkg::OUT_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  btpc_pkg::in_word_t                   in_data,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output btpc_pkg::out_word_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [15:0] t1_r, p1_r;
  logic [31:0] t23_r, p23_r, p45_r, p67_r, p89_r;
  btpc_pkg::coef_t     coef;
  btpc_pkg::mid_word_t mid_wdata, mid_rdata;
  btpc_pkg::out_word_t out_wdata;
  logic mid_push, mid_pop, mid_full, mid_empty;
  logic out_push, out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t23_r <= '0;
      p1_r  <= '0;
      p23_r <= '0;
      p45_r <= '0;
      p67_r <= '0;
      p89_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btpc_pkg::REG_T1:  t1_r  <= cfg_wdata[15:0];
        btpc_pkg::REG_T23: t23_r <= cfg_wdata;
        btpc_pkg::REG_P1:  p1_r  <= cfg_wdata[15:0];
        btpc_pkg::REG_P23: p23_r <= cfg_wdata;
        btpc_pkg::REG_P45: p45_r <= cfg_wdata;
        btpc_pkg::REG_P67: p67_r <= cfg_wdata;
        btpc_pkg::REG_P89: p89_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign coef = '{t1: t1_r, t2: t23_r[15:0], t3: t23_r[31:16],
                  p1: p1_r, p2: p23_r[15:0], p3: p23_r[31:16],
                  p4: p45_r[15:0], p5: p45_r[31:16],
                  p6: p67_r[15:0], p7: p67_r[31:16],
                  p8: p89_r[15:0], p9: p89_r[31:16]};

  btpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  btpc_fifo #(
    .WIDTH ($bits(btpc_pkg::mid_word_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  btpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  btpc_fifo #(
    .WIDTH ($bits(btpc_pkg::out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (out_pop && !out_empty),
    .rdata (out_data),
    .full  (out_full),
    .empty (out_empty)
  );

endmodule

// ===== bench/compensation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compensation_checker
// Watches both queues of the compensation block, computes the expected
// temperature and pressure words from a private copy of the calibration
// registers, and compares every popped word field by field.
// ----------------------------------------------------------------------------
module compensation_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_full,
  input  btpc_pkg::in_word_t              in_data,
  input  logic                            out_pop,
  input  logic                            out_empty,
  input  btpc_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_count
);

  logic [31:0]         cal_regs [0:6];
  btpc_pkg::out_word_t expected_words [$];

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic btpc_pkg::out_word_t compensate(input btpc_pkg::in_word_t w);
    btpc_pkg::out_word_t r;
    logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, v1, v2, q, qq, fine, p, w1, w2, ps;
    adc_p = {12'd0, w.press_msb, w.press_lsb, w.press_xlsb[7:4]};
    adc_t = {12'd0, w.temp_msb, w.temp_lsb, w.temp_xlsb[7:4]};
    t1 = {16'd0, cal_regs[btpc_pkg::REG_T1][15:0]};
    t2 = ext16(cal_regs[btpc_pkg::REG_T23][15:0]);
    t3 = ext16(cal_regs[btpc_pkg::REG_T23][31:16]);
    p1 = {16'd0, cal_regs[btpc_pkg::REG_P1][15:0]};
    p2 = ext16(cal_regs[btpc_pkg::REG_P23][15:0]);
    p3 = ext16(cal_regs[btpc_pkg::REG_P23][31:16]);
    p4 = ext16(cal_regs[btpc_pkg::REG_P45][15:0]);
    p5 = ext16(cal_regs[btpc_pkg::REG_P45][31:16]);
    p6 = ext16(cal_regs[btpc_pkg::REG_P67][15:0]);
    p7 = ext16(cal_regs[btpc_pkg::REG_P67][31:16]);
    p8 = ext16(cal_regs[btpc_pkg::REG_P89][15:0]);
    p9 = ext16(cal_regs[btpc_pkg::REG_P89][31:16]);
    a = (adc_t >> 3) - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b = (adc_t >> 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    fine = v1 + v2;
    r.fine_temperature = fine;
    r.temperature_centi = sra32(fine * 32'd5 + 32'd128, 8);
    v1 = sra32(fine, 1) - 32'd64000;
    q = sra32(v1, 2);
    qq = q * q;
    v2 = sra32(qq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra32(v2, 2) + (p4 << 16);
    v1 = sra32(sra32(p3 * sra32(qq, 13), 3) + sra32(p2 * v1, 1), 18);
    v1 = sra32((32'd32768 + v1) * p1, 15);
    if (v1 == 32'd0) begin
      r.pressure_pa = 32'd0;
      r.divide_guard = 1'b1;
    end else begin
      p = ((32'd1048576 - adc_p) - sra32(v2, 12)) * 32'd3125;
      if (p < 32'h80000000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      ps = (p >> 3) * (p >> 3);
      w1 = sra32(p9 * (ps >> 13), 12);
      w2 = sra32((p >> 2) * p8, 13);
      r.pressure_pa = p + sra32(w1 + w2 + p7, 4);
      r.divide_guard = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    btpc_pkg::out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) cal_regs[i] <= 32'd0;
      expected_words.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (in_push && !in_full) expected_words.push_back(compensate(in_data));
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data.pressure_pa, 32'd0);
        end else begin
          e = expected_words.pop_front();
          if (out_data.fine_temperature !== e.fine_temperature)
            report_mismatch("fine_temperature", out_data.fine_temperature,
                            e.fine_temperature);
          if (out_data.temperature_centi !== e.temperature_centi)
            report_mismatch("temperature_centi", out_data.temperature_centi,
                            e.temperature_centi);
          if (out_data.pressure_pa !== e.pressure_pa)
            report_mismatch("pressure_pa", out_data.pressure_pa, e.pressure_pa);
          if (out_data.divide_guard !== e.divide_guard)
            report_mismatch("divide_guard", 32'(out_data.divide_guard),
                            32'(e.divide_guard));
        end
      end
      pending_count <= expected_words.size();
      if (cfg_we && cfg_index < 3'd7) begin
        if (cfg_index == btpc_pkg::REG_T1 || cfg_index == btpc_pkg::REG_P1)
          cal_regs[cfg_index] <= {16'd0, cfg_wdata[15:0]};
        else
          cal_regs[cfg_index] <= cfg_wdata;
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives raw sensor words under several calibration sets, from all-zero and
// all-ones corners to realistic sensor values, with random gaps and pop
// stalls; the checker does the comparison and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  btpc_pkg::in_word_t in_data = '0;
  logic in_full, out_empty;
  logic out_pop = 0;
  btpc_pkg::out_word_t out_data;
  logic cfg_we = 0;
  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [btpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit stall_heavy = 0;

  always #5 clk = ~clk;

  baro_temp_pressure_compensation DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata));

  compensation_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_pop(out_pop), .out_empty(out_empty),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending_count(pending_count));

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // pop with random stalls
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 0;
    else if (stall_heavy) out_pop <= ($urandom_range(0, 9) == 0);
    else out_pop <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 5) == 0);
  end

  task automatic send_word(input btpc_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cal(input logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_set(input int kind);
    logic [btpc_pkg::CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = btpc_pkg::CFG_IDX_W'(i);
      case (kind)
        0: write_cal(idx, 32'h0);
        1: write_cal(idx, 32'hFFFF_FFFF);
        2: write_cal(idx, {1'b0, 15'h7FFF, 1'b1, 15'h0});
        3: begin
          case (idx)
            btpc_pkg::REG_T1:  write_cal(idx, 32'd27504);
            btpc_pkg::REG_T23: write_cal(idx, {16'hFC18, 16'd26435});
            btpc_pkg::REG_P1:  write_cal(idx, 32'd36477);
            btpc_pkg::REG_P23: write_cal(idx, {16'd3024, 16'hD4AB});
            btpc_pkg::REG_P45: write_cal(idx, {16'hFF73, 16'd2855});
            btpc_pkg::REG_P67: write_cal(idx, {16'd15500, 16'hFFF9});
            btpc_pkg::REG_P89: write_cal(idx, {16'd6000, 16'hB8D8});
            default: write_cal(idx, $urandom);
          endcase
        end
        default: write_cal(idx, $urandom);
      endcase
    end
    cfg_we <= 0;
  endtask

  function automatic btpc_pkg::in_word_t real_word();
    btpc_pkg::in_word_t w;
    w = 48'({$urandom, $urandom});
    w.press_msb = 8'($urandom_range(8'h40, 8'h70));
    w.temp_msb = 8'($urandom_range(8'h70, 8'h90));
    return w;
  endfunction

  initial begin
    btpc_pkg::in_word_t w;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset calibration: divide guard path
    send_word('0);
    send_word('1);
    drain();
    load_set(3);
    send_word('0);
    send_word('1);
    send_word({8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00});
    send_word({8'h65, 8'h5A, 8'hCF, 8'h7E, 8'hED, 8'h0F});
    send_word({8'h80, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00});
    send_word({8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'hF0});
    for (int i = 0; i < 8; i++) send_word(real_word());
    drain();
    load_set(1);
    send_word('0);
    send_word('1);
    drain();
    load_set(2);
    send_word('0);
    send_word('1);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      load_set(phase == 0 ? 3 : (phase == 5 ? 0 : 4));
      stall_heavy = (phase == 2);
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 3) == 0) w = 48'({$urandom, $urandom});
        else w = real_word();
        send_word(w);
      end
      drain();
    end
    stall_heavy = 0;
    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
